/* rtl/iscm_pkg.sv */
// Package for the integer scaler with CRT mask: command and register codes,
// reset values, default sizes and the CRT weight constants.
// No dependencies.
`timescale 1ns / 1ps

package iscm_pkg;

	// Field widths
	localparam int COMMAND_W = 2;
	localparam int ADDRESS_W = 17;
	localparam int COLOR_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	// Default sizes handed to the top level
	localparam int SOURCE_PIXELS_DEF = 131072;
	localparam int PALETTE_SIZE_DEF  = 16;
	localparam int MAX_VIDEO_DIM_DEF = 4096;

	// Width of the geometry arithmetic (scaled size plus offset fits in it)
	localparam int GEOM_W = 17;

	// Command codes
	localparam logic [COMMAND_W-1:0] CMD_PALETTE = 2'd0;
	localparam logic [COMMAND_W-1:0] CMD_SOURCE  = 2'd1;
	localparam logic [COMMAND_W-1:0] CMD_EMIT    = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VIDEO_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIDEO_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_INDEX  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CRT_ENABLE    = 3'd7;

	// Register reset values
	localparam logic [11:0] RST_VIDEO_WIDTH   = 12'd768;
	localparam logic [11:0] RST_VIDEO_HEIGHT  = 12'd528;
	localparam logic [10:0] RST_SOURCE_WIDTH  = 11'd320;
	localparam logic [9:0]  RST_SOURCE_HEIGHT = 10'd200;
	localparam logic [4:0]  RST_SCALE_X       = 5'd2;
	localparam logic [4:0]  RST_SCALE_Y       = 5'd2;
	localparam logic [3:0]  RST_BORDER_INDEX  = 4'd0;

	// CRT channel weights in hundredths: lit channel, other channels,
	// and both again on the darkened row
	localparam logic [6:0] W_LIT      = 7'd100;
	localparam logic [6:0] W_DIM      = 7'd60;
	localparam logic [6:0] W_LIT_DARK = 7'd70;
	localparam logic [6:0] W_DIM_DARK = 7'd42;
	localparam logic [1:0] DARK_ROW   = 2'd2;

	// floor(n / 25) = (n * RECIP_25) >> RECIP_SHIFT for n below 43690
	localparam logic [15:0] RECIP_25    = 16'd41944;
	localparam int          RECIP_SHIFT = 20;

	typedef struct packed {
		logic       enable;
		logic [1:0] col_phase;
		logic [1:0] row_phase;
	} crt_ctrl_t;

endpackage

/* rtl/iscm_div.sv */
// Two-lane restoring divider, one quotient bit per cycle, for the column
// and row source coordinates. Divisors are 5-bit scale factors.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module iscm_div #(
	parameter int W = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend_x,
	input  logic [W-1:0] dividend_y,
	input  logic [4:0]   divisor_x,
	input  logic [4:0]   divisor_y,
	output logic         last,
	output logic [W-1:0] quotient_x,
	output logic [W-1:0] quotient_y
);

	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     nx_q, ny_q;
	logic [4:0]       rx_q, ry_q;
	logic [4:0]       dx_q, dy_q;
	logic [5:0]       step_x, step_y;

	// returns {quotient bit, new remainder}
	function automatic logic [5:0] div_step(input logic [4:0] rem, input logic nbit,
			input logic [4:0] d);
		logic [5:0] t;
		logic [5:0] diff;
		t = {rem, nbit};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d})
			return {1'b1, diff[4:0]};
		return {1'b0, t[4:0]};
	endfunction

	assign step_x = div_step(rx_q, nx_q[W-1], dx_q);
	assign step_y = div_step(ry_q, ny_q[W-1], dy_q);
	assign last = busy_q && (cnt_q == CNT_W'(1));
	assign quotient_x = nx_q;
	assign quotient_y = ny_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nx_q <= dividend_x;
			ny_q <= dividend_y;
			rx_q <= '0;
			ry_q <= '0;
			dx_q <= divisor_x;
			dy_q <= divisor_y;
		end else if (busy_q) begin
			nx_q <= {nx_q[W-2:0], step_x[5]};
			ny_q <= {ny_q[W-2:0], step_y[5]};
			rx_q <= step_x[4:0];
			ry_q <= step_y[4:0];
		end
	end

endmodule

/* rtl/iscm_crt.sv */
// CRT curve and phosphor mask: contrast, brightness and per-channel weight,
// products registered, then divided by 200 and clamped.
// Depends on iscm_pkg.
`timescale 1ns / 1ps

module iscm_crt
	import iscm_pkg::*;
(
	input  logic               clk,
	input  logic               load,
	input  crt_ctrl_t          ctrl,
	input  logic [COLOR_W-1:0] color_in,
	output logic [COLOR_W-1:0] color_out
);

	logic [16:0]        prod_s1 [3];
	logic [COLOR_W-1:0] color_s1;
	logic               enable_s1;
	logic [7:0]         chan_out [3];

	always_ff @(posedge clk) begin
		if (load) begin
			color_s1 <= color_in;
			enable_s1 <= ctrl.enable;
			for (int ch = 0; ch < 3; ch++) begin
				logic [9:0] c10;
				logic [9:0] num;
				logic [6:0] w;
				c10 = {2'b00, color_in[8*ch +: 8]};
				// 3c - 8, floored at zero
				num = (c10 >= 10'd3) ? ((c10 << 1) + c10 - 10'd8) : 10'd0;
				if (ctrl.col_phase == 2'(ch))
					w = (ctrl.row_phase == DARK_ROW) ? W_LIT_DARK : W_LIT;
				else
					w = (ctrl.row_phase == DARK_ROW) ? W_DIM_DARK : W_DIM;
				prod_s1[ch] <= 17'(num) * 17'(w);
			end
		end
	end

	// divide by 200 as (p >> 3) / 25 through the reciprocal, then clamp
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			logic [29:0] m;
			logic [9:0]  q;
			m = 30'(prod_s1[ch][16:3]) * 30'(RECIP_25);
			q = m[29:RECIP_SHIFT];
			chan_out[ch] = (q > 10'd255) ? 8'hFF : q[7:0];
		end
	end

	assign color_out = enable_s1 ? {color_s1[31:24], chan_out[2], chan_out[1], chan_out[0]}
		: color_s1;

endmodule

/* rtl/integer_scaler_crt_mask_core.sv */
// Top level of the nearest-neighbour integer upscaler with CRT mask.
// Depends on iscm_pkg, iscm_div and iscm_crt.
`timescale 1ns / 1ps

// Items on the input channel either load the palette, load one source pixel
// or emit the next output pixel in raster order; other command codes are
// taken and ignored. An emit item holds the block from acceptance until its
// pixel is in the output register, and no item is taken meanwhile: the
// source coordinates come out of a divider that produces one quotient bit
// per cycle, followed by a registered read of the source memory, a registered
// read of the palette memory and the CRT unit. The finished pixel waits in
// the output register, so a new item is taken while it is still unclaimed.
// SOURCE_PIXELS and PALETTE_SIZE must be powers of two; addresses and colour
// indexes wrap on them. Both memories hold garbage until written, and nothing
// clears them. Configuration writes are for an idle block only.

module integer_scaler_crt_mask_core
	import iscm_pkg::*;
#(
	parameter int SOURCE_PIXELS = SOURCE_PIXELS_DEF,
	parameter int PALETTE_SIZE  = PALETTE_SIZE_DEF,
	parameter int MAX_VIDEO_DIM = MAX_VIDEO_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  write_enable,
	input  logic [CFG_IDX_W-1:0]  write_index,
	input  logic [CFG_DATA_W-1:0] write_data,
	// input items
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic [COMMAND_W-1:0]  command,
	input  logic [ADDRESS_W-1:0]  address,
	input  logic [COLOR_W-1:0]    value,
	// result items
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [COLOR_W-1:0]    pixel_color,
	output logic                  end_of_line,
	output logic                  end_of_frame
);

	localparam int SRC_AW = $clog2(SOURCE_PIXELS);
	localparam int PAL_AW = $clog2(PALETTE_SIZE);
	localparam int CNT_W  = $clog2(MAX_VIDEO_DIM);
	localparam int SUM_W  = (SRC_AW > 22) ? SRC_AW : 22;
	localparam int PIDX_W = (PAL_AW > 4) ? PAL_AW : 4;
	localparam int EXT_W  = ((CNT_W > 12) ? CNT_W : 12) + 1;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_MUL  = 10'b0000000010,
		S_OFF  = 10'b0000000100,
		S_POS  = 10'b0000001000,
		S_DIV  = 10'b0000010000,
		S_MULI = 10'b0000100000,
		S_SRC  = 10'b0001000000,
		S_PAL  = 10'b0010000000,
		S_CRT1 = 10'b0100000000,
		S_CRT2 = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	// configuration registers
	logic [11:0] video_width_q, video_height_q;
	logic [10:0] source_width_q;
	logic [9:0]  source_height_q;
	logic [4:0]  scale_x_q, scale_y_q;
	logic [3:0]  border_index_q;
	logic        crt_enable_q;

	// zero registers act as one
	logic [11:0] vw, vh;
	logic [10:0] sw;
	logic [9:0]  sh;
	logic [4:0]  sx, sy;

	// raster position
	logic [CNT_W-1:0] col_q, row_q;
	logic [1:0]       cph_q, rph_q;

	// item registers for the emit in progress
	logic [CNT_W-1:0] x_q, y_q;
	logic [1:0]       item_cph_q, item_rph_q;
	logic             eol_q, eof_q;
	logic [GEOM_W-1:0] scw_q, sch_q, offx_q, offy_q;
	logic             inside_q;
	logic [SUM_W-1:0] prod_q;

	// memories
	logic [3:0]         source_mem [SOURCE_PIXELS];
	logic [COLOR_W-1:0] palette_mem [PALETTE_SIZE];
	logic [3:0]         src_rd_q;
	logic [COLOR_W-1:0] pal_rd_q;

	// output register
	logic               result_valid_q;
	logic [COLOR_W-1:0] pixel_color_q;
	logic               end_of_line_q, end_of_frame_q;

	logic             item_fire, emit_fire, out_free;
	logic [EXT_W-1:0] x_next, y_next;
	logic             eol, eof;
	logic [SUM_W-1:0] addr_ext, src_sum;
	logic [SRC_AW-1:0] src_waddr, src_raddr;
	logic [PIDX_W-1:0] pal_idx_ext;
	logic [PAL_AW-1:0] pal_raddr;
	logic [GEOM_W-1:0] x_geom, y_geom, numx, numy, qx_ext, qy_ext;
	logic             in_x, in_y;
	logic             div_last;
	logic [CNT_W-1:0] quot_x, quot_y;
	crt_ctrl_t        crt_ctrl;
	logic [COLOR_W-1:0] crt_color;

	assign vw = (video_width_q == '0) ? 12'd1 : video_width_q;
	assign vh = (video_height_q == '0) ? 12'd1 : video_height_q;
	assign sw = (source_width_q == '0) ? 11'd1 : source_width_q;
	assign sh = (source_height_q == '0) ? 10'd1 : source_height_q;
	assign sx = (scale_x_q == '0) ? 5'd1 : scale_x_q;
	assign sy = (scale_y_q == '0) ? 5'd1 : scale_y_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_width_q <= RST_VIDEO_WIDTH;
			video_height_q <= RST_VIDEO_HEIGHT;
			source_width_q <= RST_SOURCE_WIDTH;
			source_height_q <= RST_SOURCE_HEIGHT;
			scale_x_q <= RST_SCALE_X;
			scale_y_q <= RST_SCALE_Y;
			border_index_q <= RST_BORDER_INDEX;
			crt_enable_q <= 1'b0;
		end else if (write_enable) begin
			unique case (write_index)
				REG_VIDEO_WIDTH:   video_width_q <= write_data;
				REG_VIDEO_HEIGHT:  video_height_q <= write_data;
				REG_SOURCE_WIDTH:  source_width_q <= write_data[10:0];
				REG_SOURCE_HEIGHT: source_height_q <= write_data[9:0];
				REG_SCALE_X:       scale_x_q <= write_data[4:0];
				REG_SCALE_Y:       scale_y_q <= write_data[4:0];
				REG_BORDER_INDEX:  border_index_q <= write_data[3:0];
				REG_CRT_ENABLE:    crt_enable_q <= write_data[0];
				default: ;
			endcase
		end
	end

	assign item_ready = (state_q == S_IDLE);
	assign item_fire = item_valid && item_ready;
	assign emit_fire = item_fire && (command == CMD_EMIT);
	assign out_free = !result_valid_q || result_ready;

	// end of line and frame for the pixel at the current raster position
	assign x_next = EXT_W'(col_q) + EXT_W'(1);
	assign y_next = EXT_W'(row_q) + EXT_W'(1);
	assign eol = (x_next >= EXT_W'(vw)) || (x_next >= EXT_W'(MAX_VIDEO_DIM));
	assign eof = eol && ((y_next >= EXT_W'(vh)) || (y_next >= EXT_W'(MAX_VIDEO_DIM)));

	// advance the raster counters as each emit item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cph_q <= '0;
			rph_q <= '0;
		end else if (emit_fire) begin
			if (eol) begin
				col_q <= '0;
				cph_q <= '0;
				if (eof) begin
					row_q <= '0;
					rph_q <= '0;
				end else begin
					row_q <= row_q + CNT_W'(1);
					rph_q <= (rph_q >= 2'd2) ? 2'd0 : rph_q + 2'd1;
				end
			end else begin
				col_q <= col_q + CNT_W'(1);
				cph_q <= (cph_q >= 2'd2) ? 2'd0 : cph_q + 2'd1;
			end
		end
	end

	// hold the position and flags of the emit in progress
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			x_q <= col_q;
			y_q <= row_q;
			item_cph_q <= cph_q;
			item_rph_q <= rph_q;
			eol_q <= eol;
			eof_q <= eof;
		end
	end

	// geometry: scaled size, centring offset, inside test, source coordinates
	assign x_geom = GEOM_W'(x_q);
	assign y_geom = GEOM_W'(y_q);
	assign in_x = (x_geom >= offx_q) && (x_geom < offx_q + scw_q);
	assign in_y = (y_geom >= offy_q) && (y_geom < offy_q + sch_q);
	assign numx = in_x ? x_geom - offx_q : '0;
	assign numy = in_y ? y_geom - offy_q : '0;

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			scw_q <= GEOM_W'(sw) * GEOM_W'(sx);
			sch_q <= GEOM_W'(sh) * GEOM_W'(sy);
		end
		if (state_q == S_OFF) begin
			offx_q <= (GEOM_W'(vw) > scw_q) ? (GEOM_W'(vw) - scw_q) >> 1 : '0;
			offy_q <= (GEOM_W'(vh) > sch_q) ? (GEOM_W'(vh) - sch_q) >> 1 : '0;
		end
		if (state_q == S_POS)
			inside_q <= in_x && in_y;
		if (state_q == S_MULI)
			prod_q <= SUM_W'(qy_ext[9:0]) * SUM_W'(sw);
	end

	iscm_div #(
		.W(CNT_W)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (state_q == S_POS),
		.dividend_x (numx[CNT_W-1:0]),
		.dividend_y (numy[CNT_W-1:0]),
		.divisor_x  (sx),
		.divisor_y  (sy),
		.last       (div_last),
		.quotient_x (quot_x),
		.quotient_y (quot_y)
	);

	// inside the image the quotients stay below the source size
	assign qx_ext = GEOM_W'(quot_x);
	assign qy_ext = GEOM_W'(quot_y);

	// memory addresses, wrapped on the memory sizes
	assign addr_ext = SUM_W'(address);
	assign src_waddr = addr_ext[SRC_AW-1:0];
	assign src_sum = prod_q + SUM_W'(qx_ext[10:0]);
	assign src_raddr = src_sum[SRC_AW-1:0];
	assign pal_idx_ext = inside_q ? PIDX_W'(src_rd_q) : PIDX_W'(border_index_q);
	assign pal_raddr = pal_idx_ext[PAL_AW-1:0];

	// source memory: written by source items, read once per emit.
	// Writes only happen in the idle state, so no read can overlap one.
	always_ff @(posedge clk) begin
		if (item_fire && (command == CMD_SOURCE))
			source_mem[src_waddr] <= value[3:0];
		if (state_q == S_SRC)
			src_rd_q <= source_mem[src_raddr];
	end

	// palette memory
	always_ff @(posedge clk) begin
		if (item_fire && (command == CMD_PALETTE))
			palette_mem[address[PAL_AW-1:0]] <= value;
		if (state_q == S_PAL)
			pal_rd_q <= palette_mem[pal_raddr];
	end

	assign crt_ctrl = '{enable: crt_enable_q, col_phase: item_cph_q, row_phase: item_rph_q};

	iscm_crt u_crt (
		.clk       (clk),
		.load      (state_q == S_CRT1),
		.ctrl      (crt_ctrl),
		.color_in  (pal_rd_q),
		.color_out (crt_color)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (emit_fire) state_d = S_MUL;
			S_MUL:  state_d = S_OFF;
			S_OFF:  state_d = S_POS;
			S_POS:  state_d = S_DIV;
			S_DIV:  if (div_last) state_d = S_MULI;
			S_MULI: state_d = S_SRC;
			S_SRC:  state_d = S_PAL;
			S_PAL:  state_d = S_CRT1;
			S_CRT1: state_d = S_CRT2;
			S_CRT2: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// output register: drop the item when taken, load the next pixel when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if ((state_q == S_CRT2) && out_free)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_CRT2) && out_free) begin
			pixel_color_q <= crt_color;
			end_of_line_q <= eol_q;
			end_of_frame_q <= eof_q;
		end
	end

	assign result_valid = result_valid_q;
	assign pixel_color = pixel_color_q;
	assign end_of_line = end_of_line_q;
	assign end_of_frame = end_of_frame_q;

endmodule

/* verif/iscm_stream_checker.sv */
// Checker for the integer scaler with CRT mask: watches the configuration
// port and both item channels, predicts every output pixel and compares it.
// Depends on iscm_pkg.
`timescale 1ns / 1ps

module iscm_stream_checker
	import iscm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  write_enable,
	input  logic [CFG_IDX_W-1:0]  write_index,
	input  logic [CFG_DATA_W-1:0] write_data,
	input  logic                  item_valid,
	input  logic                  item_ready,
	input  logic [COMMAND_W-1:0]  command,
	input  logic [ADDRESS_W-1:0]  address,
	input  logic [COLOR_W-1:0]    value,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  logic [COLOR_W-1:0]    pixel_color,
	input  logic                  end_of_line,
	input  logic                  end_of_frame,
	// where the next output pixel reads the source frame, if it does
	output logic                  next_inside,
	output logic [ADDRESS_W-1:0]  next_address,
	output int                    mismatches,
	output int                    pending
);

	localparam int SRC_DEPTH = SOURCE_PIXELS_DEF;
	localparam int PAL_DEPTH = PALETTE_SIZE_DEF;
	localparam int MAX_DIM   = MAX_VIDEO_DIM_DEF;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               eol;
		logic               eof;
	} pixel_t;

	typedef struct packed {
		logic                 in_image;
		logic [ADDRESS_W-1:0] addr;
	} site_t;

	logic [COLOR_W-1:0] palette [PAL_DEPTH];
	logic [3:0]         frame [SRC_DEPTH];
	logic [11:0]        vid_w, vid_h;
	logic [10:0]        src_w;
	logic [9:0]         src_h;
	logic [4:0]         scl_x, scl_y;
	logic [3:0]         border;
	logic               crt_on;
	logic [11:0]        col, row;
	logic [1:0]         col_ph, row_ph;
	site_t              site_now;
	pixel_t             pixels_due [$];

	assign next_inside  = site_now.in_image;
	assign next_address = site_now.addr;

	function automatic int at_least_one(int v);
		return (v == 0) ? 1 : v;
	endfunction

	// Source entry behind the current raster position, if it lies in the image
	function automatic site_t source_site();
		int vw, vh, scw, sch, sx, sy, offx, offy, x, y;
		site_t s;
		vw  = at_least_one(int'(vid_w));
		vh  = at_least_one(int'(vid_h));
		sx  = at_least_one(int'(scl_x));
		sy  = at_least_one(int'(scl_y));
		scw = at_least_one(int'(src_w)) * sx;
		sch = at_least_one(int'(src_h)) * sy;
		offx = (vw > scw) ? (vw - scw) / 2 : 0;
		offy = (vh > sch) ? (vh - sch) / 2 : 0;
		x = int'(col);
		y = int'(row);
		s.in_image = (x >= offx) && (x < offx + scw) && (y >= offy) && (y < offy + sch);
		s.addr = '0;
		if (s.in_image)
			s.addr = ADDRESS_W'((((y - offy) / sy) * at_least_one(int'(src_w))
				+ (x - offx) / sx) % SRC_DEPTH);
		return s;
	endfunction

	// Contrast curve and phosphor mask on r, g and b; alpha passes
	function automatic logic [COLOR_W-1:0] crt_shade(logic [COLOR_W-1:0] c,
			logic [1:0] cph, logic [1:0] rph);
		logic [COLOR_W-1:0] r;
		int num, f, q;
		r = c & 32'hFF00_0000;
		for (int ch = 0; ch < 3; ch++) begin
			if (rph == DARK_ROW)
				f = (ch == cph) ? int'(W_LIT_DARK) : int'(W_DIM_DARK);
			else
				f = (ch == cph) ? int'(W_LIT) : int'(W_DIM);
			num = 3 * int'(c[8*ch +: 8]) - 8;
			q = (num <= 0) ? 0 : (num * f) / 200;
			if (q > 255)
				q = 255;
			r[8*ch +: 8] = q[7:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t px, want;
		int     vw, vh;
		logic [3:0] idx;
		if (!arst_n) begin
			vid_w  = RST_VIDEO_WIDTH;
			vid_h  = RST_VIDEO_HEIGHT;
			src_w  = RST_SOURCE_WIDTH;
			src_h  = RST_SOURCE_HEIGHT;
			scl_x  = RST_SCALE_X;
			scl_y  = RST_SCALE_Y;
			border = RST_BORDER_INDEX;
			crt_on = 1'b0;
			col = '0; row = '0; col_ph = '0; row_ph = '0;
			pixels_due.delete();
			mismatches = 0;
		end else begin
			if (write_enable) begin
				case (write_index)
					REG_VIDEO_WIDTH:   vid_w  = write_data[11:0];
					REG_VIDEO_HEIGHT:  vid_h  = write_data[11:0];
					REG_SOURCE_WIDTH:  src_w  = write_data[10:0];
					REG_SOURCE_HEIGHT: src_h  = write_data[9:0];
					REG_SCALE_X:       scl_x  = write_data[4:0];
					REG_SCALE_Y:       scl_y  = write_data[4:0];
					REG_BORDER_INDEX:  border = write_data[3:0];
					REG_CRT_ENABLE:    crt_on = write_data[0];
					default: ;
				endcase
			end

			// retire the oldest pixel before queuing a new one
			if (result_valid && result_ready) begin
				if (pixels_due.size() == 0) begin
					$display("%0t: pixel with none expected: colour %h eol %b eof %b",
						$time, pixel_color, end_of_line, end_of_frame);
					mismatches++;
				end else begin
					want = pixels_due.pop_front();
					if (pixel_color !== want.color) begin
						$display("%0t: pixel_color expected %h, got %h",
							$time, want.color, pixel_color);
						mismatches++;
					end
					if (end_of_line !== want.eol) begin
						$display("%0t: end_of_line expected %b, got %b",
							$time, want.eol, end_of_line);
						mismatches++;
					end
					if (end_of_frame !== want.eof) begin
						$display("%0t: end_of_frame expected %b, got %b",
							$time, want.eof, end_of_frame);
						mismatches++;
					end
				end
			end

			if (item_valid && item_ready) begin
				case (command)
					CMD_PALETTE: palette[address % PAL_DEPTH] = value;
					CMD_SOURCE:  frame[address % SRC_DEPTH] = value[3:0];
					CMD_EMIT: begin
						site_now = source_site();
						idx = site_now.in_image ? frame[site_now.addr] : border;
						px.color = palette[idx % PAL_DEPTH];
						if (crt_on)
							px.color = crt_shade(px.color, col_ph, row_ph);
						vw = at_least_one(int'(vid_w));
						vh = at_least_one(int'(vid_h));
						px.eol = (int'(col) + 1 >= vw) || (int'(col) + 1 >= MAX_DIM);
						px.eof = px.eol &&
							((int'(row) + 1 >= vh) || (int'(row) + 1 >= MAX_DIM));
						pixels_due = {pixels_due, px};
						if (px.eol) begin
							col = '0;
							col_ph = '0;
							if (px.eof) begin
								row = '0;
								row_ph = '0;
							end else begin
								row = row + 1'b1;
								row_ph = (row_ph >= 2'd2) ? 2'd0 : row_ph + 2'd1;
							end
						end else begin
							col = col + 1'b1;
							col_ph = (col_ph >= 2'd2) ? 2'd0 : col_ph + 2'd1;
						end
					end
					default: ;
				endcase
			end
		end
		site_now = source_site();
		pending = pixels_due.size();
	end

endmodule

/* verif/integer_scaler_crt_mask_core_test.sv */
// Testbench top for integer_scaler_crt_mask_core: clock, reset, item and
// configuration stimulus, and the verdict. Depends on iscm_pkg, the block
// and iscm_stream_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module integer_scaler_crt_mask_core_test;
	import iscm_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int SRC_DEPTH   = SOURCE_PIXELS_DEF;
	localparam int ITEM_TARGET = 1150;
	// emits are the slowest items, plus stalls; this is several times the slowest run
	localparam int CYCLE_LIMIT = 500000;
	// enough to let a loading item finish after the last pixel has left
	localparam int SETTLE      = 30;
	// command code with no meaning: the block must swallow it silently
	localparam logic [COMMAND_W-1:0] CMD_NONE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  write_enable = 1'b0;
	logic [CFG_IDX_W-1:0]  write_index = '0;
	logic [CFG_DATA_W-1:0] write_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	logic [COMMAND_W-1:0]  command = '0;
	logic [ADDRESS_W-1:0]  address = '0;
	logic [COLOR_W-1:0]    value = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [COLOR_W-1:0]    pixel_color;
	logic                  end_of_line;
	logic                  end_of_frame;

	logic                  next_inside;
	logic [ADDRESS_W-1:0]  next_address;
	int                    mismatches;
	int                    pending;

	// source entries loaded so far; an emit never reads one that is not
	bit                    written [SRC_DEPTH];
	int                    items_sent = 0;
	int                    cycles = 0;
	// no idling on either side while set
	bit                    calm = 1'b0;

	always #(HALF_PERIOD) clk = ~clk;

	integer_scaler_crt_mask_core i_dut (.*);

	iscm_stream_checker i_check (.*);

	// Give up on a hung block
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("integer_scaler_crt_mask_core regression: fail");
			$finish;
		end
	end

	// Receiver: drop ready in short random bursts, hold it high when calm
	initial begin : result_side
		int n;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 4);
				result_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	// Offer one item and hold it until taken. Entered and left at a falling
	// edge; valid is left high so back-to-back items never toggle it.
	task automatic send_item(logic [COMMAND_W-1:0] cmd, logic [ADDRESS_W-1:0] addr,
			logic [COLOR_W-1:0] val);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		command    <= cmd;
		address    <= addr;
		value      <= val;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		@(negedge clk);
		if (cmd == CMD_SOURCE)
			written[addr] = 1'b1;
		if (cmd != CMD_NONE)
			items_sent++;
	endtask

	// Emit the next pixel, loading its source entry first if still blank
	task automatic emit_pixel();
		if (next_inside && !written[next_address])
			send_item(CMD_SOURCE, next_address, $urandom());
		send_item(CMD_EMIT, ADDRESS_W'($urandom()), $urandom());
	endtask

	// Stop offering, wait for every pixel owed, then let the block settle
	task automatic drain();
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		write_enable <= 1'b1;
		write_index  <= idx;
		write_data   <= data;
		@(negedge clk);
	endtask

	// Write every register on an idle block
	task automatic configure(logic [CFG_DATA_W-1:0] vw, vh, sw, sh, sx, sy, bi, crt);
		drain();
		put_reg(REG_VIDEO_WIDTH, vw);
		put_reg(REG_VIDEO_HEIGHT, vh);
		put_reg(REG_SOURCE_WIDTH, sw);
		put_reg(REG_SOURCE_HEIGHT, sh);
		put_reg(REG_SCALE_X, sx);
		put_reg(REG_SCALE_Y, sy);
		put_reg(REG_BORDER_INDEX, bi);
		put_reg(REG_CRT_ENABLE, crt);
		write_enable <= 1'b0;
	endtask

	// Mostly pixels, mixed with stray loads, palette rewrites, dead commands
	// and the odd pause until the output has caught up
	task automatic run_phase(int steps);
		int pick;
		for (int s = 0; s < steps; s++) begin
			pick = $urandom_range(0, 99);
			if (pick < 72)
				emit_pixel();
			else if (pick < 84)
				send_item(CMD_SOURCE, ADDRESS_W'($urandom()), $urandom());
			else if (pick < 91)
				send_item(CMD_PALETTE, ADDRESS_W'($urandom()), $urandom());
			else if (pick < 95)
				send_item(CMD_NONE, ADDRESS_W'($urandom()), $urandom());
			else if (pick < 97)
				drain();
			else
				emit_pixel();
		end
	endtask

	initial begin : stimulus
		logic [COLOR_W-1:0] shades [6];
		logic [CFG_DATA_W-1:0] vw;
		shades[0] = 32'h0000_0000;
		shades[1] = 32'hFFFF_FFFF;
		shades[2] = 32'h8080_8080;
		// channels 2, 4 and 3 straddle the black floor of the curve
		shades[3] = 32'h5A03_0402;
		// 173 sits just below the white clamp, 174 just above
		shades[4] = 32'hC3AE_AD03;
		shades[5] = 32'h00FF_00AE;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Load the whole palette, upper address bits set so they must wrap
		for (int i = 0; i < PALETTE_SIZE_DEF; i++)
			send_item(CMD_PALETTE, {(ADDRESS_W-4)'($urandom()), 4'(i)},
				(i < 6) ? shades[i] : $urandom());
		// Only the low nibble of a source value is kept
		send_item(CMD_SOURCE, '0, 32'hFFFF_FFF5);
		send_item(CMD_SOURCE, '1, 32'h0000_000A);
		send_item(CMD_NONE, '1, '1);
		// Reset geometry: the top rows are border
		repeat (3) emit_pixel();

		// Every register zero: sizes and scales act as one, a one-pixel frame
		configure(0, 0, 0, 0, 0, 0, 0, 0);
		run_phase(12);

		// Every register all ones, CRT on, stop part way along row 0
		configure('1, '1, '1, '1, '1, '1, '1, '1);
		run_phase(60);

		// Shrink the frame under the column counter
		configure(7, 3, 2, 1, 2, 1, 5, 1);
		run_phase(40);

		// One pixel per row, widest source: row addresses wrap the store
		configure(1, 70, 12'h7FF, 12'h3FF, 1, 1, 9, 0);
		repeat (75) emit_pixel();

		// Source far larger than the frame, no offset
		configure(30, 8, 1024, 512, 1, 1, 3, 1);
		run_phase(80);

		// Random small geometries until enough items have gone in
		while (items_sent < ITEM_TARGET) begin
			vw = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(1, 4095))
				: CFG_DATA_W'($urandom_range(1, 24));
			configure(vw, CFG_DATA_W'($urandom_range(1, 12)),
				CFG_DATA_W'($urandom_range(1, 12)), CFG_DATA_W'($urandom_range(1, 8)),
				CFG_DATA_W'($urandom_range(1, 4)), CFG_DATA_W'($urandom_range(1, 3)),
				CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 1)));
			calm = (items_sent > 1000) || ($urandom_range(0, 4) == 0);
			run_phase($urandom_range(30, 90));
		end

		drain();
		if (mismatches == 0 && pending == 0)
			$display("integer_scaler_crt_mask_core regression: pass");
		else
			$display("integer_scaler_crt_mask_core regression: fail");
		$finish;
	end

endmodule

/* files.f */
rtl/iscm_pkg.sv
rtl/iscm_div.sv
rtl/iscm_crt.sv
rtl/integer_scaler_crt_mask_core.sv
verif/iscm_stream_checker.sv
verif/integer_scaler_crt_mask_core_test.sv
